@@ hw/rtl/gtl_pkg.sv @@
// ----------------------------------------------------------------------------
// gtl_pkg
// Types and constants shared by the G-code token lexer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package gtl_pkg;

    // token kinds
    localparam logic [4:0] TK_EOF    = 5'd0;
    localparam logic [4:0] TK_EOL    = 5'd1;
    localparam logic [4:0] TK_N      = 5'd2;
    localparam logic [4:0] TK_G      = 5'd3;
    localparam logic [4:0] TK_M      = 5'd4;
    localparam logic [4:0] TK_O      = 5'd5;
    localparam logic [4:0] TK_VAR    = 5'd6;
    localparam logic [4:0] TK_NUM    = 5'd7;
    localparam logic [4:0] TK_EQ     = 5'd8;
    localparam logic [4:0] TK_LBR    = 5'd9;
    localparam logic [4:0] TK_RBR    = 5'd10;
    localparam logic [4:0] TK_ADD    = 5'd11;
    localparam logic [4:0] TK_SUBOP  = 5'd12;
    localparam logic [4:0] TK_MUL    = 5'd13;
    localparam logic [4:0] TK_DIV    = 5'd14;
    localparam logic [4:0] TK_X      = 5'd15;
    localparam logic [4:0] TK_Y      = 5'd16;
    localparam logic [4:0] TK_Z      = 5'd17;
    localparam logic [4:0] TK_F      = 5'd18;
    localparam logic [4:0] TK_P      = 5'd19;
    localparam logic [4:0] TK_R      = 5'd20;
    localparam logic [4:0] TK_S      = 5'd21;
    localparam logic [4:0] TK_T      = 5'd22;
    localparam logic [4:0] TK_SUBKW  = 5'd23;
    localparam logic [4:0] TK_ENDSUB = 5'd24;
    localparam logic [4:0] TK_CALL   = 5'd25;
    localparam logic [4:0] TK_ERR    = 5'd26;

    // error kinds
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_NESTED = 2'd1;
    localparam logic [1:0] ERR_KWORD  = 2'd2;
    localparam logic [1:0] ERR_SYMBOL = 2'd3;

    localparam logic [19:0] INT_MAX = 20'hFFFFF;

    // keyword match positions
    localparam logic [3:0] KW_START  = 4'd0;
    localparam logic [3:0] KW_S      = 4'd1;
    localparam logic [3:0] KW_SUB    = 4'd3;
    localparam logic [3:0] KW_C      = 4'd4;
    localparam logic [3:0] KW_CALL   = 4'd7;
    localparam logic [3:0] KW_E      = 4'd8;
    localparam logic [3:0] KW_EDONE  = 4'd13;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } t_lex_in;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [19:0] int_value;
        logic [19:0] minor_value;
        logic        has_minor;
        logic [31:0] real_value;
        logic [1:0]  error_kind;
        logic        last_result;
    } t_lex_out;

    // expected next lower-case letter at a keyword match position
    function automatic logic [7:0] kw_expect(input logic [3:0] pos);
        logic [7:0] r;
        case (pos)
            4'd1:    r = "u";
            4'd2:    r = "b";
            4'd4:    r = "a";
            4'd5:    r = "l";
            4'd6:    r = "l";
            4'd8:    r = "n";
            4'd9:    r = "d";
            4'd10:   r = "s";
            4'd11:   r = "u";
            4'd12:   r = "b";
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gcode_token_lexer.sv @@
// ----------------------------------------------------------------------------
// gcode_token_lexer
// Streaming G-code tokenizer: one text byte per request, zero to two tokens.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// input   | in        | i_valid / o_stall    | gtl_pkg::t_lex_in  i_data
// output  | out       | o_valid / i_stall    | gtl_pkg::t_lex_out o_data
//
// One byte is taken per cycle unless the input stalls, which it does only when
// the output buffer cannot take a second token. A byte that gives two tokens
// stalls the input while the second drains from a two-entry output buffer.
// Integers and whole parts take one multiply-by-ten and add per byte, fraction
// digits a weighted add. Reset is synchronous, clearing lexer state and buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module gcode_token_lexer #(
    parameter int FRAC_DIGITS = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire gtl_pkg::t_lex_in    i_data,
    output logic                     o_valid,
    input  wire                      i_stall,
    output gtl_pkg::t_lex_out        o_data
);

    typedef enum logic [3:0] {
        MD_IDLE, MD_COMMENT, MD_AFTER_CR, MD_N, MD_M, MD_O, MD_VAR,
        MD_GMAJ, MD_GMIN, MD_NUM, MD_S, MD_WORD
    } t_mode;

    localparam logic [32:0] SCALE = 33'(10 ** FRAC_DIGITS);

    // lexer state
    t_mode        r_mode, n_mode;
    logic [19:0]  r_int, n_int;
    logic [19:0]  r_major, n_major;
    logic [31:0]  r_real, n_real;
    logic [2:0]   r_frac, n_frac;
    logic [1:0]   r_dots, n_dots;
    logic [3:0]   r_wm, n_wm;
    logic         r_wbad, n_wbad;

    // output buffer, entry 0 is the head
    gtl_pkg::t_lex_out r_buf [2];
    logic [1:0]        r_cnt;

    gtl_pkg::t_lex_out tk [2];
    logic [1:0]        ntk;

    logic       take;
    logic [7:0] c, u, lc;
    logic       is_dig, is_alp;
    logic [3:0] dig;

    assign c      = i_data.char_in;
    assign is_dig = (c >= "0") && (c <= "9");
    assign is_alp = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    assign u      = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    assign lc     = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    assign dig    = 4'(c - "0");

    // fraction digit weight 10^(FRAC_DIGITS-1-frac)
    function automatic logic [32:0] frac_weight(input logic [2:0] f);
        logic [32:0] w;
        w = 33'd1;
        for (int k = 0; k < 8; k++) begin
            if (k < FRAC_DIGITS - 1 - int'(f)) w = w * 33'd10;
        end
        return w;
    endfunction

    function automatic gtl_pkg::t_lex_out mk(input logic [4:0] k, input logic [1:0] e);
        gtl_pkg::t_lex_out t;
        t = '0;
        t.token_kind = k;
        t.error_kind = e;
        return t;
    endfunction

    // accept while a second token still fits
    assign o_stall = (r_cnt == 2'd2) || ((r_cnt == 2'd1) && i_stall);
    assign take    = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[0];

    // per-byte lexer step
    always_comb begin
        gtl_pkg::t_lex_out fin;
        logic       has_fin, do_disp;
        logic [35:0] imul;
        logic [39:0] rmul;
        logic [33:0] radd;
        logic [3:0]  wm_in;
        logic        wb_in;
        n_mode = r_mode; n_int = r_int; n_major = r_major; n_real = r_real;
        n_frac = r_frac; n_dots = r_dots; n_wm = r_wm; n_wbad = r_wbad;
        tk[0] = '0; tk[1] = '0; ntk = 2'd0;
        fin = '0; has_fin = 1'b0; do_disp = 1'b0;
        imul = 36'(r_int) * 36'd10 + 36'(dig);
        rmul = 40'(r_real) * 40'd10 + 40'(dig) * 40'(SCALE);
        radd = 34'(r_real) + 34'(34'(dig) * 34'(frac_weight(r_frac)));
        wm_in = r_wm; wb_in = r_wbad;

        // pending token as it would be flushed
        case (r_mode)
            MD_N:    begin fin = mk(gtl_pkg::TK_N, gtl_pkg::ERR_NONE); fin.int_value = r_int; has_fin = 1'b1; end
            MD_M:    begin fin = mk(gtl_pkg::TK_M, gtl_pkg::ERR_NONE); fin.int_value = r_int; has_fin = 1'b1; end
            MD_O:    begin fin = mk(gtl_pkg::TK_O, gtl_pkg::ERR_NONE); fin.int_value = r_int; has_fin = 1'b1; end
            MD_VAR:  begin fin = mk(gtl_pkg::TK_VAR, gtl_pkg::ERR_NONE); fin.int_value = r_int; has_fin = 1'b1; end
            MD_GMAJ: begin fin = mk(gtl_pkg::TK_G, gtl_pkg::ERR_NONE); fin.int_value = r_int; has_fin = 1'b1; end
            MD_GMIN: begin
                fin = mk(gtl_pkg::TK_G, gtl_pkg::ERR_NONE);
                fin.int_value = r_major; fin.minor_value = r_int; fin.has_minor = 1'b1;
                has_fin = 1'b1;
            end
            MD_NUM:  begin fin = mk(gtl_pkg::TK_NUM, gtl_pkg::ERR_NONE); fin.real_value = r_real; has_fin = 1'b1; end
            MD_S:    begin fin = mk(gtl_pkg::TK_S, gtl_pkg::ERR_NONE); has_fin = 1'b1; end
            MD_WORD: begin
                has_fin = 1'b1;
                if (!r_wbad && r_wm == gtl_pkg::KW_SUB) fin = mk(gtl_pkg::TK_SUBKW, gtl_pkg::ERR_NONE);
                else if (!r_wbad && r_wm == gtl_pkg::KW_CALL) fin = mk(gtl_pkg::TK_CALL, gtl_pkg::ERR_NONE);
                else if (!r_wbad && r_wm == gtl_pkg::KW_EDONE) fin = mk(gtl_pkg::TK_ENDSUB, gtl_pkg::ERR_NONE);
                else fin = mk(gtl_pkg::TK_ERR, gtl_pkg::ERR_KWORD);
            end
            default: has_fin = 1'b0;
        endcase

        if (i_data.end_of_input) begin
            if (has_fin) begin tk[0] = fin; ntk = 2'd1; end
            tk[ntk[0]] = mk(gtl_pkg::TK_EOF, gtl_pkg::ERR_NONE);
            ntk = ntk + 2'd1;
            n_mode = MD_IDLE; n_int = '0; n_major = '0; n_real = '0;
            n_frac = '0; n_dots = '0; n_wm = gtl_pkg::KW_START; n_wbad = 1'b0;
        end else begin
            case (r_mode)
                MD_COMMENT: begin
                    if (c == ")") n_mode = MD_IDLE;
                    else if (c == "(") begin
                        n_mode = MD_IDLE;
                        tk[0] = mk(gtl_pkg::TK_ERR, gtl_pkg::ERR_NESTED); ntk = 2'd1;
                    end
                end
                MD_AFTER_CR: begin
                    n_mode = MD_IDLE;
                    if (c != 8'h0A) do_disp = 1'b1;
                end
                MD_N, MD_M, MD_O, MD_VAR, MD_GMAJ, MD_GMIN: begin
                    if (is_dig) n_int = (imul > 36'(gtl_pkg::INT_MAX)) ? gtl_pkg::INT_MAX : imul[19:0];
                    else if (r_mode == MD_GMAJ && c == ".") begin
                        n_major = r_int; n_int = '0; n_mode = MD_GMIN;
                    end else do_disp = 1'b1;
                end
                MD_NUM: begin
                    if (c == ".") begin
                        if (r_dots < 2'd2) n_dots = r_dots + 2'd1;
                    end else if (is_dig) begin
                        if (r_dots == 2'd0)
                            n_real = (rmul > 40'hFFFFFFFF) ? 32'hFFFFFFFF : rmul[31:0];
                        else if (r_dots == 2'd1 && 32'(r_frac) < 32'(FRAC_DIGITS)) begin
                            n_real = (radd > 34'hFFFFFFFF) ? 32'hFFFFFFFF : radd[31:0];
                            n_frac = r_frac + 3'd1;
                        end
                    end else do_disp = 1'b1;
                end
                MD_S: begin
                    if (is_alp) begin
                        n_mode = MD_WORD; wm_in = gtl_pkg::KW_S; wb_in = 1'b0;
                    end else do_disp = 1'b1;
                end
                MD_WORD: begin
                    if (!is_alp) do_disp = 1'b1;
                end
                default: do_disp = 1'b1;
            endcase

            // keyword letter match
            if ((r_mode == MD_S || r_mode == MD_WORD) && is_alp) begin
                n_wm = wm_in; n_wbad = wb_in;
                if (!wb_in) begin
                    if (gtl_pkg::kw_expect(wm_in) != 8'd0 && gtl_pkg::kw_expect(wm_in) == lc)
                        n_wm = wm_in + 4'd1;
                    else n_wbad = 1'b1;
                end
            end

            // flush pending token, then treat the byte as fresh
            if (do_disp) begin
                if (r_mode != MD_IDLE && r_mode != MD_AFTER_CR && has_fin) begin
                    tk[0] = fin; ntk = 2'd1;
                end
                n_mode = MD_IDLE;
                case (u)
                    8'h20, 8'h09: ;
                    "(": n_mode = MD_COMMENT;
                    8'h0D: begin
                        n_mode = MD_AFTER_CR;
                        tk[ntk[0]] = mk(gtl_pkg::TK_EOL, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1;
                    end
                    8'h0A: begin tk[ntk[0]] = mk(gtl_pkg::TK_EOL, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "N": begin n_mode = MD_N; n_int = '0; end
                    "G": begin n_mode = MD_GMAJ; n_int = '0; end
                    "M": begin n_mode = MD_M; n_int = '0; end
                    "O": begin n_mode = MD_O; n_int = '0; end
                    "#": begin n_mode = MD_VAR; n_int = '0; end
                    "S": n_mode = MD_S;
                    "=": begin tk[ntk[0]] = mk(gtl_pkg::TK_EQ, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "[": begin tk[ntk[0]] = mk(gtl_pkg::TK_LBR, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "]": begin tk[ntk[0]] = mk(gtl_pkg::TK_RBR, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "+": begin tk[ntk[0]] = mk(gtl_pkg::TK_ADD, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "-": begin tk[ntk[0]] = mk(gtl_pkg::TK_SUBOP, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "*": begin tk[ntk[0]] = mk(gtl_pkg::TK_MUL, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "/": begin tk[ntk[0]] = mk(gtl_pkg::TK_DIV, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "X": begin tk[ntk[0]] = mk(gtl_pkg::TK_X, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "Y": begin tk[ntk[0]] = mk(gtl_pkg::TK_Y, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "Z": begin tk[ntk[0]] = mk(gtl_pkg::TK_Z, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "F": begin tk[ntk[0]] = mk(gtl_pkg::TK_F, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "P": begin tk[ntk[0]] = mk(gtl_pkg::TK_P, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "R": begin tk[ntk[0]] = mk(gtl_pkg::TK_R, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    "T": begin tk[ntk[0]] = mk(gtl_pkg::TK_T, gtl_pkg::ERR_NONE); ntk = ntk + 2'd1; end
                    default: begin
                        if (is_dig) begin
                            n_mode = MD_NUM;
                            n_real = 32'(33'(dig) * SCALE);
                            n_frac = '0; n_dots = '0;
                        end else if (is_alp) begin
                            n_mode = MD_WORD; n_wbad = 1'b0; n_wm = gtl_pkg::KW_START;
                            if (lc == "s") n_wm = gtl_pkg::KW_S;
                            else if (lc == "c") n_wm = gtl_pkg::KW_C;
                            else if (lc == "e") n_wm = gtl_pkg::KW_E;
                            else n_wbad = 1'b1;
                        end else begin
                            tk[ntk[0]] = mk(gtl_pkg::TK_ERR, gtl_pkg::ERR_SYMBOL);
                            ntk = ntk + 2'd1;
                        end
                    end
                endcase
            end
        end
        if (ntk == 2'd1) tk[0].last_result = 1'b1;
        if (ntk == 2'd2) tk[1].last_result = 1'b1;
    end

    // lexer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MD_IDLE; r_int <= '0; r_major <= '0; r_real <= '0;
            r_frac <= '0; r_dots <= '0; r_wm <= gtl_pkg::KW_START; r_wbad <= 1'b0;
        end else if (take) begin
            r_mode <= n_mode; r_int <= n_int; r_major <= n_major; r_real <= n_real;
            r_frac <= n_frac; r_dots <= n_dots; r_wm <= n_wm; r_wbad <= n_wbad;
        end
    end

    // output buffer: pop head, then append new tokens
    always_ff @(posedge i_clk) begin
        gtl_pkg::t_lex_out b0, b1;
        logic [1:0] base;
        logic       pop;
        pop  = o_valid && !i_stall;
        base = r_cnt - {1'b0, pop};
        b0   = pop ? r_buf[1] : r_buf[0];
        b1   = r_buf[1];
        if (take && ntk != 2'd0) begin
            if (base == 2'd0) begin
                b0 = tk[0];
                if (ntk == 2'd2) b1 = tk[1];
            end else b1 = tk[0];
        end
        r_buf[0] <= b0;
        r_buf[1] <= b1;
        if (!i_rst_n) r_cnt <= 2'd0;
        else r_cnt <= base + (take ? ntk : 2'd0);
    end

endmodule

`default_nettype wire

@@ hw/rtl/gcode_token_lexer_checker.sv @@
// ----------------------------------------------------------------------------
// gcode_token_lexer_checker
// Port-level checks on the G-code token lexer, bound to the lexer module.
// ----------------------------------------------------------------------------
`default_nettype none

module gcode_token_lexer_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_valid,
    input wire                    o_stall,
    input wire gtl_pkg::t_lex_in  i_data,
    input wire                    o_valid,
    input wire                    i_stall,
    input wire gtl_pkg::t_lex_out o_data
);

    // stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("token changed under stall");

    // an end-of-file token carries the last flag
    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.token_kind == gtl_pkg::TK_EOF |-> o_data.last_result)
        else $error("eof not last");

    // error kind only on error tokens
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.token_kind != gtl_pkg::TK_ERR |->
        o_data.error_kind == gtl_pkg::ERR_NONE)
        else $error("error kind on non-error token");

    // no output right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("token after reset");

endmodule

bind gcode_token_lexer gcode_token_lexer_checker u_checker (.*);

`default_nettype wire
